@@ design/i2cee_pkg.sv @@
`timescale 1ns / 1ps

package i2cee_pkg;

  localparam int unsigned AckWaitLimitInt = 255;
  localparam logic [7:0] ACK_WAIT_LIMIT = 8'(AckWaitLimitInt);
  localparam logic [6:0] DEV_ADDR_RESET = 7'h50;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] word_address;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
  } res_t;

endpackage

@@ design/i2c_eeprom_byte_master_unit.sv @@
`timescale 1ns / 1ps
// Channel  | Direction | Handshake                    | Content
// s_axis   | in        | s_axis_tvalid / s_axis_tready | one bus phase tick and command
// m_axis   | out       | m_axis_tvalid / m_axis_tready | line levels and status per tick
// cfg      | in        | cfg_valid_i / cfg_ready_o     | seven-bit device address
//
// One tick per clock cycle sustained while m_axis accepts; each tick is held in the input
// queue at the accepting edge, then passes the phase sequencer into its output register.
// The sequencer retires one queued tick per cycle whenever the output register is free.
// Reset releases both lines, empties the queue and loads device address 0x50.
// An m_axis stall backs up the queue; s_axis_tready drops once both entries are held.

module i2c_eeprom_byte_master_unit import i2cee_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // word_address[7:0], write_data[15:8], sda_in[16], zero
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // scl_out[0], sda_out[1], busy_res[2], read_data[10:3]
  output logic        m_axis_tlast,   // done_res
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i
);

  logic  q_valid;
  logic  q_pop;
  item_t q_item;
  res_t  res;

  assign cfg_ready_o = 1'b1;

  i2cee_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .opcode_i       (s_axis_tuser),
    .word_address_i (s_axis_tdata[7:0]),
    .write_data_i   (s_axis_tdata[15:8]),
    .sda_in_i       (s_axis_tdata[16]),
    .q_valid_o      (q_valid),
    .q_pop_i        (q_pop),
    .q_item_o       (q_item)
  );

  i2cee_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_item_i    (q_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {5'd0, res.read_data, res.busy_res, res.sda_out, res.scl_out};
  assign m_axis_tlast = res.done_res;

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[2])
    else $error("done tick reports busy");

  a_done_lines_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[0] && m_axis_tdata[1])
    else $error("bus lines not released after stop");

  a_full_queue_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> q_valid)
    else $error("input stalled with empty queue");

  a_pop_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> m_axis_tvalid)
    else $error("popped tick did not reach output");
`endif

endmodule

@@ design/i2cee_front.sv @@
`timescale 1ns / 1ps

module i2cee_front import i2cee_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  word_address_i,
  input  logic [7:0]  write_data_i,
  input  logic        sda_in_i,
  output logic        q_valid_o,
  input  logic        q_pop_i,
  output item_t       q_item_o
);

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  item_t      item_in;

  always_comb begin
    item_in.word_address = word_address_i;
    item_in.write_data   = write_data_i;
    item_in.sda_in       = sda_in_i;
    unique case (opcode_i)
      2'd1:    item_in.cmd = CMD_READ;
      2'd2:    item_in.cmd = CMD_WRITE;
      default: item_in.cmd = CMD_NONE;
    endcase
  end

  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

@@ design/i2cee_seq.sv @@
`timescale 1ns / 1ps

module i2cee_seq import i2cee_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  input  item_t       q_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output res_t        out_res_o
);

  localparam logic [2:0] K_IDLE  = 3'd0;
  localparam logic [2:0] K_START = 3'd1;
  localparam logic [2:0] K_WBYTE = 3'd2;
  localparam logic [2:0] K_ACK   = 3'd3;
  localparam logic [2:0] K_READ  = 3'd4;
  localparam logic [2:0] K_STOP  = 3'd5;

  function automatic logic [2:0] seg_kind(logic [3:0] seg, logic is_write);
    logic [2:0] k;
    k = K_IDLE;
    if (is_write) begin
      unique case (seg)
        4'd1:                k = K_START;
        4'd2, 4'd4, 4'd6:    k = K_WBYTE;
        4'd3, 4'd5, 4'd7:    k = K_ACK;
        4'd8:                k = K_STOP;
        default:             k = K_IDLE;
      endcase
    end else begin
      unique case (seg)
        4'd1, 4'd6:          k = K_START;
        4'd2, 4'd4, 4'd7:    k = K_WBYTE;
        4'd3, 4'd5, 4'd8:    k = K_ACK;
        4'd9:                k = K_READ;
        4'd10:               k = K_STOP;
        default:             k = K_IDLE;
      endcase
    end
    return k;
  endfunction

  logic [6:0] dev_q;
  logic [3:0] seg_q, seg_d;
  logic [1:0] sub_q, sub_d;
  logic [3:0] bit_cnt_q, bit_cnt_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] ack_cnt_q, ack_cnt_d;
  logic       is_write_q, is_write_d;
  logic [7:0] addr_q, addr_d;
  logic [7:0] data_q, data_d;
  logic [7:0] rx_q, rx_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       done;
  logic       enter;
  logic [3:0] tgt;
  logic       out_valid_q;
  res_t       res_q;

  assign q_pop_o     = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  always_comb begin
    seg_d      = seg_q;
    sub_d      = sub_q;
    bit_cnt_d  = bit_cnt_q;
    shift_d    = shift_q;
    ack_cnt_d  = ack_cnt_q;
    is_write_d = is_write_q;
    addr_d     = addr_q;
    data_d     = data_q;
    rx_d       = rx_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    done       = 1'b0;
    enter      = 1'b0;
    tgt        = seg_q + 4'd1;
    if (seg_q == 4'd0) begin
      sub_d = 2'd0;
      if (q_item_i.cmd != CMD_NONE) begin
        is_write_d = (q_item_i.cmd == CMD_WRITE);
        addr_d     = q_item_i.word_address;
        data_d     = q_item_i.write_data;
        enter      = 1'b1;
        tgt        = 4'd1;
      end
    end else begin
      unique case (seg_kind(seg_q, is_write_q))
        K_START: begin
          unique case (sub_q)
            2'd0: sda_d = 1'b1;
            2'd1: scl_d = 1'b1;
            2'd2: sda_d = 1'b0;
            default: begin
              scl_d = 1'b0;
              enter = 1'b1;
            end
          endcase
          sub_d = sub_q + 2'd1;
        end
        K_WBYTE: begin
          if (bit_cnt_q[3]) begin
            if (sub_q == 2'd0) begin
              scl_d = 1'b0;
              sub_d = 2'd1;
            end else begin
              sda_d = 1'b1;
              enter = 1'b1;
            end
          end else begin
            unique case (sub_q)
              2'd0: begin
                scl_d = 1'b0;
                sub_d = 2'd1;
              end
              2'd1: begin
                sda_d   = shift_q[7];
                shift_d = {shift_q[6:0], 1'b0};
                sub_d   = 2'd2;
              end
              default: begin
                scl_d     = 1'b1;
                bit_cnt_d = bit_cnt_q + 4'd1;
                sub_d     = 2'd0;
              end
            endcase
          end
        end
        K_ACK: begin
          if (sub_q == 2'd0) begin
            scl_d     = 1'b1;
            ack_cnt_d = 8'd0;
            sub_d     = 2'd1;
          end else if (!q_item_i.sda_in || ack_cnt_q >= ACK_WAIT_LIMIT) begin
            scl_d = 1'b0;
            enter = 1'b1;
          end else begin
            ack_cnt_d = ack_cnt_q + 8'd1;
          end
        end
        K_READ: begin
          unique case (sub_q)
            2'd0: begin
              scl_d = 1'b0;
              sub_d = 2'd1;
            end
            2'd1: begin
              sda_d     = 1'b1;
              bit_cnt_d = 4'd0;
              shift_d   = 8'd0;
              sub_d     = 2'd2;
            end
            2'd2: begin
              scl_d   = 1'b1;
              shift_d = {shift_q[6:0], q_item_i.sda_in};
              sub_d   = 2'd3;
            end
            default: begin
              scl_d     = 1'b0;
              bit_cnt_d = bit_cnt_q + 4'd1;
              if (bit_cnt_d[3]) begin
                enter = 1'b1;
              end else begin
                sub_d = 2'd2;
              end
            end
          endcase
        end
        K_STOP: begin
          if (sub_q == 2'd0) begin
            sda_d = 1'b0;
            sub_d = 2'd1;
          end else if (sub_q == 2'd1) begin
            scl_d = 1'b1;
            sub_d = 2'd2;
          end else begin
            sda_d = 1'b1;
            if (!is_write_q) begin
              rx_d = shift_q;
            end
            done  = 1'b1;
            seg_d = 4'd0;
            sub_d = 2'd0;
          end
        end
        default: begin
          seg_d = 4'd0;
          sub_d = 2'd0;
        end
      endcase
    end
    if (enter) begin
      seg_d     = tgt;
      sub_d     = 2'd0;
      bit_cnt_d = 4'd0;
      if (seg_kind(tgt, is_write_d) == K_WBYTE) begin
        priority if (tgt == 4'd2) begin
          shift_d = {dev_q, 1'b0};
        end else if (tgt == 4'd4) begin
          shift_d = addr_d;
        end else if (is_write_d) begin
          shift_d = data_d;
        end else begin
          shift_d = {dev_q, 1'b1};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q       <= DEV_ADDR_RESET;
      seg_q       <= 4'd0;
      sub_q       <= 2'd0;
      bit_cnt_q   <= 4'd0;
      shift_q     <= 8'd0;
      ack_cnt_q   <= 8'd0;
      is_write_q  <= 1'b0;
      addr_q      <= 8'd0;
      data_q      <= 8'd0;
      rx_q        <= 8'd0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dev_q <= cfg_data_i;
      end
      if (q_pop_o) begin
        seg_q       <= seg_d;
        sub_q       <= sub_d;
        bit_cnt_q   <= bit_cnt_d;
        shift_q     <= shift_d;
        ack_cnt_q   <= ack_cnt_d;
        is_write_q  <= is_write_d;
        addr_q      <= addr_d;
        data_q      <= data_d;
        rx_q        <= rx_d;
        scl_q       <= scl_d;
        sda_q       <= sda_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q.scl_out   <= scl_d;
      res_q.sda_out   <= sda_d;
      res_q.busy_res  <= (seg_d != 4'd0);
      res_q.done_res  <= done;
      res_q.read_data <= rx_d;
    end
  end

endmodule
